// ===== rtl/mesh_dewarp_bilinear_sampler_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the mesh dewarp sampler
// Immediate-free concurrent checks that drop out of synthesis builds.
// ---------------------------------------------------------------------------
`ifndef MESH_DEWARP_BILINEAR_SAMPLER_MACROS_SVH
`define MESH_DEWARP_BILINEAR_SAMPLER_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define MDB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition in one cycle that implies a consequence in the next cycle.
`define MDB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MDB_ASSERT(label, clk, rst, prop, msg)
`define MDB_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/mdb_pkg.sv =====
// ---------------------------------------------------------------------------
// Mesh dewarp sampler package
// Field widths, default parameters, codes and the interpolation helpers.
// ---------------------------------------------------------------------------
package mdb_pkg;

   localparam int STORE_LINES_DEF = 32;
   localparam int STORE_WIDTH_DEF = 2048;
   localparam int MESH_NODES_DEF  = 64;
   localparam int FRAC_BITS_DEF   = 12;
   localparam int PIXEL_MAX_DEF   = 1023;

   localparam int COORD_W    = 24;
   localparam int POS_W      = 13;
   localparam int PIX_W      = 10;
   localparam int NODE_IDX_W = 6;
   localparam int GAIN_W     = 8;
   localparam int PGAIN_W    = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [1:0] {
      OP_SAMPLE  = 2'd0,
      OP_MESH    = 2'd1,
      OP_COMPUTE = 2'd2
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BLOCK_SIZE_LOG2  = 3'd0,
      REG_WINDOW_START_ROW = 3'd1,
      REG_WINDOW_START_COL = 3'd2,
      REG_WINDOW_HEIGHT    = 3'd3,
      REG_WINDOW_WIDTH     = 3'd4
   } csr_index_type;

   // a + floor(g * (b - a) / 2^sh); the result lies between a and b when g is at most 2^sh.
   function automatic logic [COORD_W-1:0] mesh_lerp(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b,
                                                    input logic [GAIN_W-1:0] g,
                                                    input logic [3:0] sh);
      logic signed [COORD_W+1:0]        diff;
      logic signed [COORD_W+GAIN_W+2:0] prod;
      diff = $signed({2'b00, b}) - $signed({2'b00, a});
      prod = diff * $signed({1'b0, g});
      prod = prod >>> sh;
      return prod[COORD_W-1:0] + a;
   endfunction

   // a + round(g * (b - a) / 2^sh), rounding half up.
   function automatic logic [PIX_W-1:0] pix_lerp(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b,
                                                 input logic [PGAIN_W-1:0] g,
                                                 input logic [4:0] sh);
      logic signed [PIX_W:0]           diff;
      logic signed [PIX_W+PGAIN_W+1:0] prod;
      logic signed [PIX_W+PGAIN_W+1:0] rnd;
      diff = $signed({1'b0, b}) - $signed({1'b0, a});
      prod = diff * $signed({1'b0, g});
      rnd = '0;
      rnd[sh - 5'd1] = 1'b1;
      prod = (prod + rnd) >>> sh;
      return prod[PIX_W-1:0] + a;
   endfunction

endpackage

// ===== rtl/mdb_ram.sv =====
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ---------------------------------------------------------------------------
module mdb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mesh_dewarp_bilinear_sampler.sv =====
// ---------------------------------------------------------------------------
// Mesh dewarp bilinear sampler
// Line stores, mesh rows and a six-stage sampling pipeline.
// ---------------------------------------------------------------------------
// The block takes one item per clock while no result waits at the output. The
// rate is set by the pipeline around the two memory reads: the mesh banks are
// read in the cycle of the transfer and the line-store banks in stage 3, each
// store split into four banks by row and column parity so all four neighbors
// come out of one read. Sample writes reach the line stores at that same stage,
// so every compute sees exactly the writes that came before it. When a result
// waits at the output the whole pipeline holds. STORE_LINES and STORE_WIDTH must
// be powers of two. The stores need no clearing pass after reset.
`include "mesh_dewarp_bilinear_sampler_macros.svh"

module mesh_dewarp_bilinear_sampler
   import mdb_pkg::*;
#(
   parameter int STORE_LINES = STORE_LINES_DEF,
   parameter int STORE_WIDTH = STORE_WIDTH_DEF,
   parameter int MESH_NODES  = MESH_NODES_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   parameter int PIXEL_MAX   = PIXEL_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_opcode,
   input  logic [POS_W-1:0]      req_row,
   input  logic [POS_W-1:0]      req_col,
   input  logic [PIX_W-1:0]      req_luma_sample,
   input  logic [PIX_W-1:0]      req_chroma_sample,
   input  logic                  req_mesh_slot,
   input  logic [NODE_IDX_W-1:0] req_node_index,
   input  logic [COORD_W-1:0]    req_node_x,
   input  logic [COORD_W-1:0]    req_node_y,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [POS_W-1:0]      rsp_out_row,
   output logic [POS_W-1:0]      rsp_out_col,
   output logic [PIX_W-1:0]      rsp_luma_out,
   output logic [PIX_W-1:0]      rsp_chroma_out
);

   localparam int LINES_LOG2  = $clog2(STORE_LINES);
   localparam int WIDTH_LOG2  = $clog2(STORE_WIDTH);
   localparam int LBANK_DEPTH = STORE_LINES * STORE_WIDTH / 4;
   localparam int LBANK_AW    = LINES_LOG2 + WIDTH_LOG2 - 2;
   localparam int NODE_AW     = $clog2(MESH_NODES);
   localparam int MBANK_DEPTH = (MESH_NODES + 1) / 2;
   localparam int MBANK_AW    = NODE_AW - 1;
   localparam int MESH_W      = 2 * COORD_W;
   localparam int INT_W       = COORD_W - FRAC_BITS;
   localparam int CLIP_W      = ((INT_W > 15) ? INT_W : 15) + 1;
   localparam logic [POS_W-1:0]     MESH_LAST    = POS_W'(MESH_NODES - 1);
   localparam logic [FRAC_BITS:0]   G_HALF       = (FRAC_BITS + 1)'(1 << (FRAC_BITS - 1));
   localparam logic [FRAC_BITS:0]   G_THREE_HALF = (FRAC_BITS + 1)'(3 << (FRAC_BITS - 1));
   localparam logic [PIX_W-1:0]     PIX_LIMIT    =
      PIX_W'((PIXEL_MAX > 1023) ? 1023 : PIXEL_MAX);

   function automatic logic [CLIP_W-1:0] clip_to(input logic [CLIP_W-1:0] v,
                                                 input logic [CLIP_W-1:0] lo,
                                                 input logic [CLIP_W-1:0] hi);
      if (v < lo) begin
         return lo;
      end
      if (v > hi) begin
         return hi;
      end
      return v;
   endfunction

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [2:0]  bs_log2_ff, bs_log2_in;
   logic [12:0] win_row_ff, win_row_in;
   logic [12:0] win_col_ff, win_col_in;
   logic [13:0] win_h_ff, win_h_in;
   logic [11:0] win_w_ff, win_w_in;

   assign csr_ready = 1'b1;

   always_comb begin
      bs_log2_in = bs_log2_ff;
      win_row_in = win_row_ff;
      win_col_in = win_col_ff;
      win_h_in   = win_h_ff;
      win_w_in   = win_w_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_BLOCK_SIZE_LOG2:  bs_log2_in = csr_wdata[2:0];
            REG_WINDOW_START_ROW: win_row_in = csr_wdata[12:0];
            REG_WINDOW_START_COL: win_col_in = csr_wdata[12:0];
            REG_WINDOW_HEIGHT:    win_h_in   = csr_wdata[13:0];
            REG_WINDOW_WIDTH:     win_w_in   = csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bs_log2_ff <= 3'd4;
         win_row_ff <= '0;
         win_col_ff <= '0;
         win_h_ff   <= 14'd1080;
         win_w_ff   <= 12'd1920;
      end else begin
         bs_log2_ff <= bs_log2_in;
         win_row_ff <= win_row_in;
         win_col_ff <= win_col_in;
         win_h_ff   <= win_h_in;
         win_w_ff   <= win_w_in;
      end
   end

   // Effective block size and window bounds.
   logic [2:0]        bs;
   logic [6:0]        blk_mask;
   logic [7:0]        uv_mask;
   logic [13:0]       h_eff;
   logic [11:0]       w_eff;
   logic [CLIP_W-1:0] row_lo, row_hi, col_lo, col_hi, pair_lo, pair_hi;

   assign bs       = (bs_log2_ff < 3'd2) ? 3'd2 : bs_log2_ff;
   assign blk_mask = 7'((8'd1 << bs) - 8'd1);
   assign uv_mask  = 8'((9'd1 << (4'(bs) + 4'd1)) - 9'd1);
   assign h_eff    = (win_h_ff == 14'd0) ? 14'd1 : win_h_ff;
   assign w_eff    = (win_w_ff < 12'd2) ? 12'd2 : win_w_ff;
   assign row_lo   = CLIP_W'(win_row_ff);
   assign row_hi   = row_lo + CLIP_W'(h_eff) - CLIP_W'(1);
   assign col_lo   = CLIP_W'(win_col_ff);
   assign col_hi   = col_lo + CLIP_W'(w_eff) - CLIP_W'(1);
   assign pair_lo  = CLIP_W'(win_col_ff[12:1]);
   assign pair_hi  = pair_lo + CLIP_W'(w_eff[11:1]) - CLIP_W'(1);

   // ------------------------------------------------------------------
   // Pipeline control: every stage advances unless a result is stuck.
   // ------------------------------------------------------------------
   logic advance;
   logic rsp_valid_ff, rsp_valid_in;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // ------------------------------------------------------------------
   // Stage 0: gains, mesh node indexes, mesh reads and mesh writes
   // ------------------------------------------------------------------
   logic [6:0]         gh_in, gw_in;
   logic [7:0]         guv_in;
   logic [POS_W-1:0]   nl_raw, nr_raw, nl, nr;
   logic [NODE_AW-1:0] nl_idx, nr_idx, even_src, odd_src;
   logic [8:0]         node_wide;
   logic               node_ok;
   logic [NODE_AW-1:0] node_sel;
   logic               mesh_write;

   assign gh_in    = req_row[6:0] & blk_mask;
   assign gw_in    = req_col[6:0] & blk_mask;
   assign guv_in   = {req_col[6:1], 1'b0, 1'b1} & uv_mask;
   assign nl_raw   = req_col >> bs;
   assign nr_raw   = nl_raw + POS_W'(1);
   assign nl       = (nl_raw > MESH_LAST) ? MESH_LAST : nl_raw;
   assign nr       = (nr_raw > MESH_LAST) ? MESH_LAST : nr_raw;
   assign nl_idx   = nl[NODE_AW-1:0];
   assign nr_idx   = nr[NODE_AW-1:0];
   assign even_src = nl_idx[0] ? nr_idx : nl_idx;
   assign odd_src  = nl_idx[0] ? nl_idx : nr_idx;

   assign node_wide  = 9'(req_node_index);
   assign node_ok    = node_wide < 9'(MESH_NODES);
   assign node_sel   = node_wide[NODE_AW-1:0];
   assign mesh_write = req_valid && advance && (req_opcode == OP_MESH) && node_ok;

   logic [MESH_W-1:0] mesh_rd [4];

   // Mesh banks: bit 1 is the slot, bit 0 the node parity.
   for (genvar b = 0; b < 4; b++) begin : g_mesh
      localparam logic SLOT = 1'(b >> 1);
      localparam logic PAR  = 1'(b & 1);
      logic [MBANK_AW-1:0] rd_addr;
      logic                wr_en;

      assign rd_addr = PAR ? odd_src[NODE_AW-1:1] : even_src[NODE_AW-1:1];
      assign wr_en   = mesh_write && (req_mesh_slot == SLOT) && (node_sel[0] == PAR);

      mdb_ram #(
         .WIDTH (MESH_W),
         .DEPTH (MBANK_DEPTH)
      ) u_mesh_ram (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (node_sel[NODE_AW-1:1]),
         .wr_data ({req_node_x, req_node_y}),
         .rd_en   (advance),
         .rd_addr (rd_addr),
         .rd_data (mesh_rd[b])
      );
   end

   // Stage 1 registers.
   logic              s1_valid_ff;
   logic [1:0]        s1_op_ff;
   logic [POS_W-1:0]  s1_row_ff, s1_col_ff;
   logic [PIX_W-1:0]  s1_luma_ff, s1_chroma_ff;
   logic [6:0]        s1_gh_ff, s1_gw_ff;
   logic [7:0]        s1_guv_ff;
   logic              s1_nl_odd_ff, s1_nr_odd_ff;

   // ------------------------------------------------------------------
   // Stage 1: vertical interpolation of the two node columns
   // ------------------------------------------------------------------
   logic [MESH_W-1:0]  up_l, up_r, lo_l, lo_r;
   logic [COORD_W-1:0] s2_lx_in, s2_ly_in, s2_rx_in, s2_ry_in;

   assign up_l = s1_nl_odd_ff ? mesh_rd[1] : mesh_rd[0];
   assign up_r = s1_nr_odd_ff ? mesh_rd[1] : mesh_rd[0];
   assign lo_l = s1_nl_odd_ff ? mesh_rd[3] : mesh_rd[2];
   assign lo_r = s1_nr_odd_ff ? mesh_rd[3] : mesh_rd[2];

   assign s2_lx_in = mesh_lerp(up_l[MESH_W-1:COORD_W], lo_l[MESH_W-1:COORD_W],
                               {1'b0, s1_gh_ff}, 4'(bs));
   assign s2_ly_in = mesh_lerp(up_l[COORD_W-1:0], lo_l[COORD_W-1:0],
                               {1'b0, s1_gh_ff}, 4'(bs));
   assign s2_rx_in = mesh_lerp(up_r[MESH_W-1:COORD_W], lo_r[MESH_W-1:COORD_W],
                               {1'b0, s1_gh_ff}, 4'(bs));
   assign s2_ry_in = mesh_lerp(up_r[COORD_W-1:0], lo_r[COORD_W-1:0],
                               {1'b0, s1_gh_ff}, 4'(bs));

   logic               s2_valid_ff;
   logic [1:0]         s2_op_ff;
   logic [POS_W-1:0]   s2_row_ff, s2_col_ff;
   logic [PIX_W-1:0]   s2_luma_ff, s2_chroma_ff;
   logic [6:0]         s2_gw_ff;
   logic [7:0]         s2_guv_ff;
   logic [COORD_W-1:0] s2_lx_ff, s2_ly_ff, s2_rx_ff, s2_ry_ff;

   // ------------------------------------------------------------------
   // Stage 2: horizontal interpolation for luma and chroma phases
   // ------------------------------------------------------------------
   logic [COORD_W-1:0] s3_fyx_in, s3_fyy_in, s3_fux_in, s3_fuy_in;

   assign s3_fyx_in = mesh_lerp(s2_lx_ff, s2_rx_ff, {1'b0, s2_gw_ff}, 4'(bs));
   assign s3_fyy_in = mesh_lerp(s2_ly_ff, s2_ry_ff, {1'b0, s2_gw_ff}, 4'(bs));
   assign s3_fux_in = mesh_lerp(s2_lx_ff, s2_rx_ff, s2_guv_ff, 4'(bs) + 4'd1);
   assign s3_fuy_in = mesh_lerp(s2_ly_ff, s2_ry_ff, s2_guv_ff, 4'(bs) + 4'd1);

   logic               s3_valid_ff;
   logic [1:0]         s3_op_ff;
   logic [POS_W-1:0]   s3_row_ff, s3_col_ff;
   logic [PIX_W-1:0]   s3_luma_ff, s3_chroma_ff;
   logic [COORD_W-1:0] s3_fyx_ff, s3_fyy_ff, s3_fux_ff, s3_fuy_ff;

   // ------------------------------------------------------------------
   // Stage 3: window clipping, line-store reads and sample writes
   // ------------------------------------------------------------------
   logic [CLIP_W-1:0]    yh0, yh1, yw0, yw1, uh0, uh1, uw0, uw1, iu, pair, uw_clip;
   logic [FRAC_BITS-1:0] fu;
   logic [FRAC_BITS:0]   g0_in;
   logic                 left_half;
   logic                 ph;
   logic                 sample_write;

   assign yh0 = clip_to(CLIP_W'(s3_fyy_ff[COORD_W-1:FRAC_BITS]), row_lo, row_hi);
   assign yh1 = (yh0 < row_hi) ? yh0 + CLIP_W'(1) : row_hi;
   assign yw0 = clip_to(CLIP_W'(s3_fyx_ff[COORD_W-1:FRAC_BITS]), col_lo, col_hi);
   assign yw1 = (yw0 < col_hi) ? yw0 + CLIP_W'(1) : col_hi;
   assign uh0 = clip_to(CLIP_W'(s3_fuy_ff[COORD_W-1:FRAC_BITS]), row_lo, row_hi);
   assign uh1 = (uh0 < row_hi) ? uh0 + CLIP_W'(1) : row_hi;

   assign iu        = CLIP_W'(s3_fux_ff[COORD_W-1:FRAC_BITS]);
   assign fu        = s3_fux_ff[FRAC_BITS-1:0];
   assign pair      = {1'b0, iu[CLIP_W-1:1]};
   assign uw_clip   = clip_to(pair, pair_lo, pair_hi);
   // An even integer column in its left half takes the pair to the left.
   assign left_half = !iu[0] && !fu[FRAC_BITS-1];

   always_comb begin
      if (left_half) begin
         uw1   = uw_clip;
         uw0   = (uw_clip > pair_lo) ? uw_clip - CLIP_W'(1) : pair_lo;
         g0_in = {1'b0, fu} + G_THREE_HALF;
      end else begin
         uw0   = uw_clip;
         uw1   = (uw_clip < pair_hi) ? uw_clip + CLIP_W'(1) : pair_hi;
         g0_in = iu[0] ? {1'b0, fu} + G_HALF : {1'b0, fu} - G_HALF;
      end
   end

   assign ph           = s3_col_ff[0];
   assign sample_write = advance && s3_valid_ff && (s3_op_ff == OP_SAMPLE);

   logic [PIX_W-1:0] luma_rd [4];
   logic [PIX_W-1:0] chroma_rd [4];

   // Line-store banks: bit 1 is the row parity; bit 0 the column parity for
   // luma and the chroma pair parity for chroma.
   for (genvar b = 0; b < 4; b++) begin : g_line
      localparam logic RP = 1'(b >> 1);
      localparam logic CP = 1'(b & 1);
      logic [CLIP_W-1:0]   l_row, l_col, c_row, c_pair;
      logic [LBANK_AW-1:0] l_rd_addr, c_rd_addr, l_wr_addr, c_wr_addr;
      logic                l_wr_en, c_wr_en;

      assign l_row     = (yh0[0] == RP) ? yh0 : yh1;
      assign l_col     = (yw0[0] == CP) ? yw0 : yw1;
      assign c_row     = (uh0[0] == RP) ? uh0 : uh1;
      assign c_pair    = (uw0[0] == CP) ? uw0 : uw1;
      assign l_rd_addr = {l_row[LINES_LOG2-1:1], l_col[WIDTH_LOG2-1:1]};
      assign c_rd_addr = {c_row[LINES_LOG2-1:1], c_pair[WIDTH_LOG2-2:1], ph};
      assign l_wr_addr = {s3_row_ff[LINES_LOG2-1:1], s3_col_ff[WIDTH_LOG2-1:1]};
      assign c_wr_addr = {s3_row_ff[LINES_LOG2-1:1], s3_col_ff[WIDTH_LOG2-1:2],
                          s3_col_ff[0]};
      assign l_wr_en   = sample_write && (s3_row_ff[0] == RP) && (s3_col_ff[0] == CP);
      assign c_wr_en   = sample_write && (s3_row_ff[0] == RP) && (s3_col_ff[1] == CP);

      mdb_ram #(
         .WIDTH (PIX_W),
         .DEPTH (LBANK_DEPTH)
      ) u_luma_ram (
         .clock   (clock),
         .wr_en   (l_wr_en),
         .wr_addr (l_wr_addr),
         .wr_data (s3_luma_ff),
         .rd_en   (advance),
         .rd_addr (l_rd_addr),
         .rd_data (luma_rd[b])
      );

      mdb_ram #(
         .WIDTH (PIX_W),
         .DEPTH (LBANK_DEPTH)
      ) u_chroma_ram (
         .clock   (clock),
         .wr_en   (c_wr_en),
         .wr_addr (c_wr_addr),
         .wr_data (s3_chroma_ff),
         .rd_en   (advance),
         .rd_addr (c_rd_addr),
         .rd_data (chroma_rd[b])
      );
   end

   logic                 s4_valid_ff;
   logic [1:0]           s4_op_ff;
   logic [POS_W-1:0]     s4_row_ff, s4_col_ff;
   logic                 s4_yh0p_ff, s4_yh1p_ff, s4_yw0p_ff, s4_yw1p_ff;
   logic                 s4_uh0p_ff, s4_uh1p_ff, s4_uw0p_ff, s4_uw1p_ff;
   logic [FRAC_BITS-1:0] s4_gx_ff, s4_gy_ff, s4_g1_ff;
   logic [FRAC_BITS:0]   s4_g0_ff;

   // ------------------------------------------------------------------
   // Stage 4: horizontal sample interpolation
   // ------------------------------------------------------------------
   logic [PIX_W-1:0] p00, p01, p10, p11, q00, q01, q10, q11;
   logic [PIX_W-1:0] s5_t1_in, s5_t2_in, s5_s1_in, s5_s2_in;

   assign p00 = luma_rd[{s4_yh0p_ff, s4_yw0p_ff}];
   assign p01 = luma_rd[{s4_yh0p_ff, s4_yw1p_ff}];
   assign p10 = luma_rd[{s4_yh1p_ff, s4_yw0p_ff}];
   assign p11 = luma_rd[{s4_yh1p_ff, s4_yw1p_ff}];
   assign q00 = chroma_rd[{s4_uh0p_ff, s4_uw0p_ff}];
   assign q01 = chroma_rd[{s4_uh0p_ff, s4_uw1p_ff}];
   assign q10 = chroma_rd[{s4_uh1p_ff, s4_uw0p_ff}];
   assign q11 = chroma_rd[{s4_uh1p_ff, s4_uw1p_ff}];

   assign s5_t1_in = pix_lerp(p00, p01, PGAIN_W'(s4_gx_ff), 5'(FRAC_BITS));
   assign s5_t2_in = pix_lerp(p10, p11, PGAIN_W'(s4_gx_ff), 5'(FRAC_BITS));
   assign s5_s1_in = pix_lerp(q00, q01, PGAIN_W'(s4_g0_ff), 5'(FRAC_BITS + 1));
   assign s5_s2_in = pix_lerp(q10, q11, PGAIN_W'(s4_g0_ff), 5'(FRAC_BITS + 1));

   logic                 s5_valid_ff;
   logic [1:0]           s5_op_ff;
   logic [POS_W-1:0]     s5_row_ff, s5_col_ff;
   logic [PIX_W-1:0]     s5_t1_ff, s5_t2_ff, s5_s1_ff, s5_s2_ff;
   logic [FRAC_BITS-1:0] s5_gy_ff, s5_g1_ff;

   // ------------------------------------------------------------------
   // Stage 5: vertical sample interpolation and output clip
   // ------------------------------------------------------------------
   logic [PIX_W-1:0] lum, chr, luma_out_in, chroma_out_in;

   assign lum           = pix_lerp(s5_t1_ff, s5_t2_ff, PGAIN_W'(s5_gy_ff), 5'(FRAC_BITS));
   assign chr           = pix_lerp(s5_s1_ff, s5_s2_ff, PGAIN_W'(s5_g1_ff), 5'(FRAC_BITS));
   assign luma_out_in   = (lum > PIX_LIMIT) ? PIX_LIMIT : lum;
   assign chroma_out_in = (chr > PIX_LIMIT) ? PIX_LIMIT : chr;
   assign rsp_valid_in  = s5_valid_ff && (s5_op_ff == OP_COMPUTE);

   logic [POS_W-1:0] rsp_row_ff, rsp_col_ff;
   logic [PIX_W-1:0] rsp_luma_ff, rsp_chroma_ff;

   // ------------------------------------------------------------------
   // Pipeline registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff      <= req_opcode;
         s1_row_ff     <= req_row;
         s1_col_ff     <= req_col;
         s1_luma_ff    <= req_luma_sample;
         s1_chroma_ff  <= req_chroma_sample;
         s1_gh_ff      <= gh_in;
         s1_gw_ff      <= gw_in;
         s1_guv_ff     <= guv_in;
         s1_nl_odd_ff  <= nl_idx[0];
         s1_nr_odd_ff  <= nr_idx[0];

         s2_op_ff      <= s1_op_ff;
         s2_row_ff     <= s1_row_ff;
         s2_col_ff     <= s1_col_ff;
         s2_luma_ff    <= s1_luma_ff;
         s2_chroma_ff  <= s1_chroma_ff;
         s2_gw_ff      <= s1_gw_ff;
         s2_guv_ff     <= s1_guv_ff;
         s2_lx_ff      <= s2_lx_in;
         s2_ly_ff      <= s2_ly_in;
         s2_rx_ff      <= s2_rx_in;
         s2_ry_ff      <= s2_ry_in;

         s3_op_ff      <= s2_op_ff;
         s3_row_ff     <= s2_row_ff;
         s3_col_ff     <= s2_col_ff;
         s3_luma_ff    <= s2_luma_ff;
         s3_chroma_ff  <= s2_chroma_ff;
         s3_fyx_ff     <= s3_fyx_in;
         s3_fyy_ff     <= s3_fyy_in;
         s3_fux_ff     <= s3_fux_in;
         s3_fuy_ff     <= s3_fuy_in;

         s4_op_ff      <= s3_op_ff;
         s4_row_ff     <= s3_row_ff;
         s4_col_ff     <= s3_col_ff;
         s4_yh0p_ff    <= yh0[0];
         s4_yh1p_ff    <= yh1[0];
         s4_yw0p_ff    <= yw0[0];
         s4_yw1p_ff    <= yw1[0];
         s4_uh0p_ff    <= uh0[0];
         s4_uh1p_ff    <= uh1[0];
         s4_uw0p_ff    <= uw0[0];
         s4_uw1p_ff    <= uw1[0];
         s4_gx_ff      <= s3_fyx_ff[FRAC_BITS-1:0];
         s4_gy_ff      <= s3_fyy_ff[FRAC_BITS-1:0];
         s4_g0_ff      <= g0_in;
         s4_g1_ff      <= s3_fuy_ff[FRAC_BITS-1:0];

         s5_op_ff      <= s4_op_ff;
         s5_row_ff     <= s4_row_ff;
         s5_col_ff     <= s4_col_ff;
         s5_t1_ff      <= s5_t1_in;
         s5_t2_ff      <= s5_t2_in;
         s5_s1_ff      <= s5_s1_in;
         s5_s2_ff      <= s5_s2_in;
         s5_gy_ff      <= s4_gy_ff;
         s5_g1_ff      <= s4_g1_ff;

         rsp_row_ff    <= s5_row_ff;
         rsp_col_ff    <= s5_col_ff;
         rsp_luma_ff   <= luma_out_in;
         rsp_chroma_ff <= chroma_out_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_out_col    = rsp_col_ff;
   assign rsp_luma_out   = rsp_luma_ff;
   assign rsp_chroma_out = rsp_chroma_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // Only compute items carry meaningful coordinates in stage 3.
   `MDB_ASSERT_NEXT(a_compute_reaches_output, clock, reset,
      advance && s5_valid_ff && (s5_op_ff == OP_COMPUTE), rsp_valid,
      "compute item in the last stage did not produce a result")
   `MDB_ASSERT(a_luma_rows_in_window, clock, reset,
      !s3_valid_ff || (s3_op_ff != OP_COMPUTE) ||
      ((yh0 >= row_lo) && (yh1 <= row_hi) && (yh1 >= yh0)),
      "clipped luma rows left the input window")
   `MDB_ASSERT(a_chroma_pairs_adjacent, clock, reset,
      !s3_valid_ff || (s3_op_ff != OP_COMPUTE) ||
      ((uw1 >= uw0) && (uw1 <= uw0 + CLIP_W'(1))),
      "chroma pair columns are not adjacent")

endmodule
